[hw/rtl/periodic_timer_scheduler_defines.svh]
// Assertion macros for the periodic timer scheduler.
// Used by pts_back; depends on nothing else.
`ifndef PERIODIC_TIMER_SCHEDULER_DEFINES_SVH
`define PERIODIC_TIMER_SCHEDULER_DEFINES_SVH
`ifndef ASSERT_OFF
`define PTS_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("pts assertion failed");
`define PTS_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pts implication failed");
`else
`define PTS_ASSERT(lbl, prop)
`define PTS_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

[hw/rtl/pts_pkg.sv]
// Shared types and constants of the periodic timer scheduler.
// Depends on nothing.
`timescale 1ns / 1ps
package pts_pkg;
   localparam int TIME_W = 48;
   localparam int PER_W = 32;
   localparam int SLOT_W = 6;
   localparam int FUNC_W = 2;
   localparam logic [TIME_W:0] STALE_LIMIT_US = 49'd10000000;

   localparam logic [FUNC_W-1:0] FUNC_ARM = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_CANCEL = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_TICK = 2'd2;

   localparam logic [1:0] OP_ARM = 2'd0;
   localparam logic [1:0] OP_CANCEL = 2'd1;
   localparam logic [1:0] OP_TICK = 2'd2;

   typedef struct packed {
      logic [1:0] op;
      logic [SLOT_W-1:0] slot;
      logic [TIME_W-1:0] deadline;
      logic [PER_W-1:0] period;
      logic periodic;
      logic [TIME_W-1:0] now;
   } cmd_type;
endpackage

[hw/rtl/pts_front.sv]
// Front end: accepts request beats, classifies them and queues commands.
// Depends on pts_pkg.
`timescale 1ns / 1ps
module pts_front #(
   parameter int NUM_TIMERS = 64
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [1:0] req_func,
   input  logic [5:0] req_timer_slot,
   input  logic [47:0] req_deadline_in,
   input  logic [31:0] req_period_in,
   input  logic req_is_periodic,
   input  logic [47:0] req_now_time,
   output logic q_valid,
   input  logic q_ready,
   output pts_pkg::cmd_type q_cmd
);
   import pts_pkg::*;

   cmd_type entry_ff [2];
   logic wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic in_range, keep, push, pop;
   cmd_type cmd;

   assign in_range = {5'd0, req_timer_slot} < 11'(NUM_TIMERS);
   assign req_ready = cnt_ff != 2'd2;

   always_comb begin
      cmd.slot = req_timer_slot;
      cmd.deadline = req_deadline_in;
      cmd.period = req_period_in;
      cmd.periodic = req_is_periodic;
      cmd.now = req_now_time;
      cmd.op = OP_TICK;
      keep = 1'b0;
      case (req_func)
         FUNC_ARM: begin
            cmd.op = OP_ARM;
            keep = in_range;
         end
         FUNC_CANCEL: begin
            cmd.op = OP_CANCEL;
            keep = in_range;
         end
         FUNC_TICK: begin
            cmd.op = OP_TICK;
            keep = 1'b1;
         end
         default: keep = 1'b0;
      endcase
   end

   assign push = req_valid && req_ready && keep;
   assign q_valid = cnt_ff != 2'd0;
   assign pop = q_valid && q_ready;
   assign q_cmd = entry_ff[rd_ptr_ff];
   assign wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
   assign rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
   assign cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= cmd;
      end
   end
endmodule

[hw/rtl/pts_back.sv]
// Back end: executes queued commands, scans the timer memories and fires.
// Depends on pts_pkg and periodic_timer_scheduler_defines.svh.
`timescale 1ns / 1ps
`include "periodic_timer_scheduler_defines.svh"
module pts_back #(
   parameter int NUM_TIMERS = 64,
   parameter int MAX_FIRES = 64
) (
   input  logic clock,
   input  logic reset,
   input  logic q_valid,
   output logic q_ready,
   input  pts_pkg::cmd_type q_cmd,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [5:0] rsp_fired_slot,
   output logic rsp_fired_periodic,
   output logic [47:0] rsp_fired_deadline,
   output logic rsp_last
);
   import pts_pkg::*;

   localparam int IDX_W = $clog2(NUM_TIMERS);
   localparam int SCAN_W = $clog2(NUM_TIMERS + 1);
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_FIRE = 2'd2;
   localparam logic [1:0] S_FLUSH = 2'd3;

   logic [TIME_W-1:0] dl_mem [NUM_TIMERS];
   logic [PER_W-1:0] per_mem [NUM_TIMERS];
   logic [TIME_W-1:0] dl_rd_ff;
   logic [PER_W-1:0] per_rd_ff;

   logic [1:0] state_ff, state_in;
   logic [NUM_TIMERS-1:0] armed_ff, armed_in, periodic_ff, periodic_in;
   logic [TIME_W-1:0] last_time_ff, last_time_in, now_ff, now_in;
   logic [SCAN_W-1:0] scan_ff, scan_in;
   logic [6:0] count_ff, count_in;
   logic best_v_ff, best_v_in;
   logic [IDX_W-1:0] best_idx_ff, best_idx_in;
   logic [TIME_W-1:0] best_dl_ff, best_dl_in;
   logic [PER_W-1:0] best_per_ff, best_per_in;
   logic pend_v_ff, pend_v_in;
   logic [5:0] pend_slot_ff, pend_slot_in;
   logic pend_per_ff, pend_per_in;
   logic [TIME_W-1:0] pend_dl_ff, pend_dl_in;
   logic out_v_ff, out_v_in;
   logic [5:0] out_slot_ff, out_slot_in;
   logic out_per_ff, out_per_in;
   logic [TIME_W-1:0] out_dl_ff, out_dl_in;
   logic out_last_ff, out_last_in;

   logic we;
   logic [IDX_W-1:0] wa, ra, data_idx;
   logic [TIME_W-1:0] wd_dl;
   logic [PER_W-1:0] wd_per;
   logic we_per;
   logic out_free;
   logic [TIME_W:0] stale_sum, next_sum;
   logic [TIME_W-1:0] arm_dl;

   assign out_free = !out_v_ff || rsp_ready;
   assign stale_sum = {1'b0, q_cmd.deadline} + STALE_LIMIT_US;
   assign arm_dl = (q_cmd.periodic && ({1'b0, last_time_ff} > stale_sum)) ?
      last_time_ff : q_cmd.deadline;
   assign next_sum = {1'b0, best_dl_ff} + {{(TIME_W + 1 - PER_W){1'b0}}, best_per_ff};
   assign ra = scan_ff[IDX_W-1:0];
   assign data_idx = IDX_W'(scan_ff - SCAN_W'(1));
   assign q_ready = state_ff == S_IDLE;

   always_comb begin
      state_in = state_ff;
      armed_in = armed_ff;
      periodic_in = periodic_ff;
      last_time_in = last_time_ff;
      now_in = now_ff;
      scan_in = scan_ff;
      count_in = count_ff;
      best_v_in = best_v_ff;
      best_idx_in = best_idx_ff;
      best_dl_in = best_dl_ff;
      best_per_in = best_per_ff;
      pend_v_in = pend_v_ff;
      pend_slot_in = pend_slot_ff;
      pend_per_in = pend_per_ff;
      pend_dl_in = pend_dl_ff;
      out_v_in = out_v_ff && !rsp_ready;
      out_slot_in = out_slot_ff;
      out_per_in = out_per_ff;
      out_dl_in = out_dl_ff;
      out_last_in = out_last_ff;
      we = 1'b0;
      we_per = 1'b0;
      wa = IDX_W'(q_cmd.slot);
      wd_dl = arm_dl;
      wd_per = q_cmd.period;
      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               case (q_cmd.op)
                  OP_ARM: begin
                     we = 1'b1;
                     we_per = 1'b1;
                     armed_in[IDX_W'(q_cmd.slot)] = 1'b1;
                     periodic_in[IDX_W'(q_cmd.slot)] = q_cmd.periodic;
                  end
                  OP_CANCEL: armed_in[IDX_W'(q_cmd.slot)] = 1'b0;
                  OP_TICK: begin
                     last_time_in = q_cmd.now;
                     now_in = q_cmd.now;
                     count_in = 7'd0;
                     scan_in = '0;
                     best_v_in = 1'b0;
                     state_in = S_SCAN;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_SCAN: begin
            if (scan_ff != '0) begin
               if (armed_ff[data_idx] && dl_rd_ff <= now_ff &&
                   (!best_v_ff || dl_rd_ff < best_dl_ff)) begin
                  best_v_in = 1'b1;
                  best_idx_in = data_idx;
                  best_dl_in = dl_rd_ff;
                  best_per_in = per_rd_ff;
               end
            end
            if (scan_ff == SCAN_W'(NUM_TIMERS)) begin
               state_in = S_FIRE;
            end else begin
               scan_in = scan_ff + SCAN_W'(1);
            end
         end
         S_FIRE: begin
            if (!best_v_ff) begin
               state_in = pend_v_ff ? S_FLUSH : S_IDLE;
            end else if (!pend_v_ff || out_free) begin
               if (pend_v_ff) begin
                  out_v_in = 1'b1;
                  out_slot_in = pend_slot_ff;
                  out_per_in = pend_per_ff;
                  out_dl_in = pend_dl_ff;
                  out_last_in = 1'b0;
               end
               pend_v_in = 1'b1;
               pend_slot_in = 6'(best_idx_ff);
               pend_dl_in = best_dl_ff;
               wa = best_idx_ff;
               wd_dl = next_sum[TIME_W-1:0];
               if (periodic_ff[best_idx_ff] && !next_sum[TIME_W]) begin
                  we = 1'b1;
                  pend_per_in = 1'b1;
               end else begin
                  armed_in[best_idx_ff] = 1'b0;
                  pend_per_in = 1'b0;
               end
               count_in = count_ff + 7'd1;
               best_v_in = 1'b0;
               scan_in = '0;
               state_in = (count_ff + 7'd1 == 7'(MAX_FIRES)) ? S_FLUSH : S_SCAN;
            end
         end
         S_FLUSH: begin
            if (out_free) begin
               out_v_in = 1'b1;
               out_slot_in = pend_slot_ff;
               out_per_in = pend_per_ff;
               out_dl_in = pend_dl_ff;
               out_last_in = 1'b1;
               pend_v_in = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         armed_ff <= '0;
         periodic_ff <= '0;
         last_time_ff <= '0;
         count_ff <= 7'd0;
         best_v_ff <= 1'b0;
         pend_v_ff <= 1'b0;
         out_v_ff <= 1'b0;
         scan_ff <= '0;
      end else begin
         state_ff <= state_in;
         armed_ff <= armed_in;
         periodic_ff <= periodic_in;
         last_time_ff <= last_time_in;
         count_ff <= count_in;
         best_v_ff <= best_v_in;
         pend_v_ff <= pend_v_in;
         out_v_ff <= out_v_in;
         scan_ff <= scan_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff <= now_in;
      best_idx_ff <= best_idx_in;
      best_dl_ff <= best_dl_in;
      best_per_ff <= best_per_in;
      pend_slot_ff <= pend_slot_in;
      pend_per_ff <= pend_per_in;
      pend_dl_ff <= pend_dl_in;
      out_slot_ff <= out_slot_in;
      out_per_ff <= out_per_in;
      out_dl_ff <= out_dl_in;
      out_last_ff <= out_last_in;
   end

   always_ff @(posedge clock) begin
      if (we) begin
         dl_mem[wa] <= wd_dl;
      end
      dl_rd_ff <= dl_mem[ra];
   end

   always_ff @(posedge clock) begin
      if (we_per) begin
         per_mem[wa] <= wd_per;
      end
      per_rd_ff <= per_mem[ra];
   end

   assign rsp_valid = out_v_ff;
   assign rsp_fired_slot = out_slot_ff;
   assign rsp_fired_periodic = out_per_ff;
   assign rsp_fired_deadline = out_dl_ff;
   assign rsp_last = out_last_ff;

   `PTS_ASSERT_IMP(a_idle_no_pending, state_ff == S_IDLE, !pend_v_ff)
   `PTS_ASSERT_IMP(a_flush_has_pending, state_ff == S_FLUSH, pend_v_ff)
   `PTS_ASSERT(a_count_bound, count_ff <= 7'(MAX_FIRES))
   `PTS_ASSERT_IMP(a_scan_bound, state_ff == S_SCAN, scan_ff <= SCAN_W'(NUM_TIMERS))
endmodule

[hw/rtl/periodic_timer_scheduler.sv]
// Top level of the periodic timer scheduler.
// Instantiates pts_front and pts_back; depends on pts_pkg.
//
// Requests (req_) carry arm, cancel and tick commands as valid/ready beats.
// A two-entry queue in the front end takes a beat per cycle while free.
// Arm and cancel are executed by the back end while idle and produce no response.
// A tick scans all NUM_TIMERS slots of the timer memories once per firing,
// and once more to find no more unless it stops at MAX_FIRES firings.
// Each firing is one response beat (rsp_); rsp_last marks the final one.
// One firing is held back until the next scan decides its last flag.
// A stalled response channel holds the output register and the back end
// waits, while the queue keeps taking request beats until full.
// Reset disarms all slots and clears the last seen time; the deadline and
// period memories are not cleared.
`timescale 1ns / 1ps
module periodic_timer_scheduler #(
   parameter int NUM_TIMERS = 64,
   parameter int MAX_FIRES = 64
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [1:0] req_func,
   input  logic [5:0] req_timer_slot,
   input  logic [47:0] req_deadline_in,
   input  logic [31:0] req_period_in,
   input  logic req_is_periodic,
   input  logic [47:0] req_now_time,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [5:0] rsp_fired_slot,
   output logic rsp_fired_periodic,
   output logic [47:0] rsp_fired_deadline,
   output logic rsp_last
);
   import pts_pkg::*;

   logic q_valid, q_ready;
   cmd_type q_cmd;

   pts_front #(.NUM_TIMERS(NUM_TIMERS)) u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_func(req_func), .req_timer_slot(req_timer_slot),
      .req_deadline_in(req_deadline_in), .req_period_in(req_period_in),
      .req_is_periodic(req_is_periodic), .req_now_time(req_now_time),
      .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
   );

   pts_back #(.NUM_TIMERS(NUM_TIMERS), .MAX_FIRES(MAX_FIRES)) u_back (
      .clock(clock), .reset(reset),
      .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_fired_slot(rsp_fired_slot), .rsp_fired_periodic(rsp_fired_periodic),
      .rsp_fired_deadline(rsp_fired_deadline), .rsp_last(rsp_last)
   );
endmodule

[verif/tb_top.sv]
// Self-checking testbench for the periodic timer scheduler: a timer-slot predictor
// computes the expected firings of every accepted request beat. Depends on pts_pkg
// and the periodic_timer_scheduler RTL.
`timescale 1ns / 1ps
module tb_top;
   import pts_pkg::*;

   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   localparam int NUM_SLOTS = 64;
   localparam int FIRE_CAP = 64;
   localparam longint CYCLE_LIMIT = 6000000;
   localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

   typedef struct {
      logic [SLOT_W-1:0] slot;
      logic periodic;
      logic [TIME_W-1:0] due;
      logic last;
   } firing_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_func = '0;
   logic [5:0] req_timer_slot = '0;
   logic [47:0] req_deadline_in = '0;
   logic [31:0] req_period_in = '0;
   logic req_is_periodic = 1'b0;
   logic [47:0] req_now_time = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [5:0] rsp_fired_slot;
   logic rsp_fired_periodic;
   logic [47:0] rsp_fired_deadline;
   logic rsp_last;

   logic [TIME_W-1:0] slot_deadline [NUM_SLOTS];
   logic [PER_W-1:0] slot_period [NUM_SLOTS];
   logic slot_armed [NUM_SLOTS];
   logic slot_periodic [NUM_SLOTS];
   logic [TIME_W-1:0] seen_time;
   firing_type pending_fires [$];

   int errors = 0;
   longint cycles = 0;
   bit no_idle = 1'b0;
   bit rsp_took = 1'b0;
   int rsp_hold = 0;
   logic [TIME_W-1:0] cur_t;

   periodic_timer_scheduler u_top (.*);

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic report(input string what);
      $display("mismatch at cycle %0d: %s", cycles, what);
      errors++;
   endtask

   function automatic int draw_wait();
      return no_idle ? 0 : $urandom_range(0, 16);
   endfunction

   function automatic void predict_tick(input logic [TIME_W-1:0] now);
      int count;
      int best;
      logic [TIME_W:0] next;
      firing_type f;
      count = 0;
      seen_time = now;
      while (count < FIRE_CAP) begin
         best = -1;
         for (int i = 0; i < NUM_SLOTS; i++)
            if (slot_armed[i] && slot_deadline[i] <= now)
               if (best < 0 || slot_deadline[i] < slot_deadline[best]) best = i;
         if (best < 0) break;
         f.slot = best[SLOT_W-1:0];
         f.due = slot_deadline[best];
         f.last = 1'b0;
         f.periodic = 1'b0;
         if (slot_periodic[best]) begin
            next = {1'b0, f.due} + {17'b0, slot_period[best]};
            if (!next[TIME_W]) begin
               slot_deadline[best] = next[TIME_W-1:0];
               f.periodic = 1'b1;
            end else begin
               slot_armed[best] = 1'b0;
            end
         end else begin
            slot_armed[best] = 1'b0;
         end
         pending_fires = {pending_fires, f};
         count++;
      end
      if (count > 0) pending_fires[$].last = 1'b1;
   endfunction

   function automatic void predict_beat();
      logic [TIME_W-1:0] dl;
      dl = req_deadline_in;
      case (req_func)
         FUNC_ARM: begin
            if (req_is_periodic && {1'b0, seen_time} > {1'b0, dl} + STALE_LIMIT_US)
               dl = seen_time;
            slot_deadline[req_timer_slot] = dl;
            slot_period[req_timer_slot] = req_period_in;
            slot_periodic[req_timer_slot] = req_is_periodic;
            slot_armed[req_timer_slot] = 1'b1;
         end
         FUNC_CANCEL: slot_armed[req_timer_slot] = 1'b0;
         FUNC_TICK: predict_tick(req_now_time);
         default: ;
      endcase
   endfunction

   // Called and returns at a falling edge.
   task automatic send_beat(input logic [1:0] func, input logic [5:0] slot,
                            input logic [47:0] dl, input logic [31:0] per,
                            input logic periodic, input logic [47:0] now);
      int gap;
      req_valid <= 1'b1;
      req_func <= func;
      req_timer_slot <= slot;
      req_deadline_in <= dl;
      req_period_in <= per;
      req_is_periodic <= periodic;
      req_now_time <= now;
      do @(posedge clock); while (!(req_valid && req_ready));
      predict_beat();
      @(negedge clock);
      gap = draw_wait();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic arm(input int slot, input logic [47:0] dl, input logic [31:0] per,
                      input logic periodic);
      send_beat(FUNC_ARM, slot[5:0], dl, per, periodic, 48'($urandom));
   endtask

   task automatic cancel(input int slot);
      send_beat(FUNC_CANCEL, slot[5:0], 48'($urandom), $urandom, 1'($urandom),
                48'($urandom));
   endtask

   task automatic tick(input logic [47:0] now);
      send_beat(FUNC_TICK, 6'($urandom), 48'($urandom), $urandom, 1'($urandom), now);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_fires.size() != 0) @(negedge clock);
   endtask

   always @(posedge clock) begin
      firing_type f;
      rsp_took <= !reset && rsp_valid && rsp_ready;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_fires.size() == 0) begin
            report($sformatf("unexpected firing of slot %0d", rsp_fired_slot));
         end else begin
            f = pending_fires.pop_front();
            if (rsp_fired_slot !== f.slot)
               report($sformatf("slot %0d, expected %0d", rsp_fired_slot, f.slot));
            if (rsp_fired_periodic !== f.periodic)
               report($sformatf("periodic %b, expected %b", rsp_fired_periodic, f.periodic));
            if (rsp_fired_deadline !== f.due)
               report($sformatf("deadline %h, expected %h", rsp_fired_deadline, f.due));
            if (rsp_last !== f.last)
               report($sformatf("last %b, expected %b", rsp_last, f.last));
         end
      end
   end

   always @(negedge clock) begin
      if (rsp_took) begin
         rsp_hold = draw_wait();
      end
      if (rsp_hold > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold--;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic test_ordering();
      tick(48'd0);
      arm(1, 48'd0, 32'd0, 1'b0);
      arm(0, 48'd100, 32'd7, 1'b0);
      arm(63, 48'd100, 32'd7, 1'b0);
      arm(5, 48'd50, 32'd30, 1'b1);
      tick(48'd200);
   endtask

   task automatic test_commands();
      cancel(5);
      cancel(5);
      send_beat(FUNC_UNUSED, 6'd63, TIME_MAX, 32'hFFFF_FFFF, 1'b1, TIME_MAX);
      tick(48'd250);
   endtask

   task automatic test_zero_period();
      arm(7, 48'd300, 32'd0, 1'b1);
      tick(48'd300);
      cancel(7);
   endtask

   task automatic test_stale_arm();
      tick(48'd50_000_000);
      arm(9, 48'd1000, 32'd1000, 1'b1);
      tick(48'd50_000_000);
      cancel(9);
   endtask

   task automatic test_overflow();
      arm(10, 48'hFFFF_FFFF_FF00, 32'hFFFF_FFFF, 1'b1);
      arm(11, TIME_MAX, 32'd1, 1'b0);
      tick(TIME_MAX);
      tick(48'd1000);
   endtask

   task automatic test_random(input int n_items);
      int pick;
      logic [47:0] now;
      cur_t = 48'd2000;
      for (int k = 0; k < n_items; k++) begin
         if ($urandom_range(0, 24) == 0) no_idle = ~no_idle;
         if (k == n_items / 2) wait_drained();
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            arm($urandom_range(0, 63), cur_t + $urandom_range(0, 4000),
                $urandom_range(500, 4000), 1'($urandom_range(0, 1)));
         end else if (pick < 45) begin
            cancel($urandom_range(0, 63));
         end else if (pick < 85) begin
            cur_t = cur_t + $urandom_range(0, 2000);
            tick(cur_t);
         end else begin
            now = ($urandom_range(0, 1) == 1) ? cur_t - $urandom_range(0, 3000) : cur_t;
            send_beat(2'($urandom_range(0, 3)), 6'($urandom), 48'({$urandom, $urandom}),
                      $urandom_range(1, 32'hFFFF_FFFF), 1'($urandom), now);
         end
      end
      no_idle = 1'b0;
   endtask

   initial begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
         slot_armed[i] = 1'b0;
         slot_periodic[i] = 1'b0;
         slot_deadline[i] = '0;
         slot_period[i] = '0;
      end
      seen_time = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_ordering();
      test_commands();
      test_zero_period();
      test_stale_arm();
      test_overflow();
      test_random(260);
      wait_drained();
      repeat (300) @(negedge clock);
      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/pts_pkg.sv
hw/rtl/pts_front.sv
hw/rtl/pts_back.sv
hw/rtl/periodic_timer_scheduler.sv
verif/tb_top.sv
